@@ design/stl_pkg.sv @@
// Shared types, token kind codes and character helpers for the source token lexer.
// Used by every module of the lexer; depends on nothing.
`timescale 1ns / 1ps
package stl_pkg;

   localparam int NUM_KW      = 11;
   localparam int BUNDLE_MAX  = 4;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [5:0] K_END      = 6'd0;
   localparam logic [5:0] K_IDENT    = 6'd1;
   localparam logic [5:0] K_INT      = 6'd2;
   localparam logic [5:0] K_STRING   = 6'd3;
   localparam logic [5:0] K_ERROR    = 6'd4;
   localparam logic [5:0] K_KW0      = 6'd5;
   localparam logic [5:0] K_DOT      = 6'd16;
   localparam logic [5:0] K_LPAREN   = 6'd17;
   localparam logic [5:0] K_RPAREN   = 6'd18;
   localparam logic [5:0] K_LBRACE   = 6'd19;
   localparam logic [5:0] K_RBRACE   = 6'd20;
   localparam logic [5:0] K_COMMA    = 6'd21;
   localparam logic [5:0] K_COLON    = 6'd22;
   localparam logic [5:0] K_SEMI     = 6'd23;
   localparam logic [5:0] K_PLUS     = 6'd24;
   localparam logic [5:0] K_MUL      = 6'd25;
   localparam logic [5:0] K_DIV      = 6'd26;
   localparam logic [5:0] K_EQEQ     = 6'd27;
   localparam logic [5:0] K_EQ       = 6'd28;
   localparam logic [5:0] K_NE       = 6'd29;
   localparam logic [5:0] K_ARROW    = 6'd30;
   localparam logic [5:0] K_MINUS    = 6'd31;
   localparam logic [5:0] K_RAILPIPE = 6'd32;
   localparam logic [5:0] K_PIPE     = 6'd33;
   localparam logic [5:0] K_LT       = 6'd34;
   localparam logic [5:0] K_GT       = 6'd35;
   localparam logic [5:0] K_MAX      = 6'd35;

   typedef struct packed {
      logic [5:0]  kind;
      logic [15:0] start;
      logic [15:0] length;
   } tok_type;

   // one request's worth of tokens, count is 1..4 when pushed
   typedef struct packed {
      logic [2:0]         count;
      tok_type [BUNDLE_MAX-1:0] tok;
   } bundle_type;

   typedef struct packed {
      logic       push;
      bundle_type data;
   } qwr_type;

   function automatic logic [63:0] kw_text(input logic [3:0] k);
      logic [63:0] t;
      unique case (k)
         4'd0:    t = {"fn", 48'h0};
         4'd1:    t = {"return", 16'h0};
         4'd2:    t = {"region", 16'h0};
         4'd3:    t = "requires";
         4'd4:    t = {"ensures", 8'h0};
         4'd5:    t = {"must", 32'h0};
         4'd6:    t = {"match", 24'h0};
         4'd7:    t = {"Ok", 48'h0};
         4'd8:    t = {"Err", 40'h0};
         4'd9:    t = {"struct", 16'h0};
         4'd10:   t = {"or", 48'h0};
         default: t = 64'h0;
      endcase
      return t;
   endfunction

   function automatic logic [3:0] kw_len(input logic [3:0] k);
      logic [3:0] l;
      unique case (k)
         4'd0, 4'd7, 4'd10:  l = 4'd2;
         4'd1, 4'd2, 4'd9:   l = 4'd6;
         4'd3:               l = 4'd8;
         4'd4:               l = 4'd7;
         4'd5:               l = 4'd4;
         4'd6:               l = 4'd5;
         4'd8:               l = 4'd3;
         default:            l = 4'd0;
      endcase
      return l;
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return c == " " || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic bundle_type add_tok(input bundle_type b, input logic [5:0] kind,
                                          input logic [15:0] start,
                                          input logic [15:0] length);
      bundle_type r;
      r = b;
      if (b.count < 3'(BUNDLE_MAX)) begin
         r.tok[b.count[1:0]].kind   = kind;
         r.tok[b.count[1:0]].start  = start;
         r.tok[b.count[1:0]].length = length;
         r.count                    = b.count + 3'd1;
      end
      return r;
   endfunction

endpackage

@@ design/stl_front.sv @@
// Front end of the lexer: per-byte token state machine, builds a token bundle per request.
// Depends on stl_pkg.
`timescale 1ns / 1ps
module stl_front #(
   parameter int POS_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              take,
   input  logic [7:0]        text_byte,
   input  logic              last_byte,
   output stl_pkg::qwr_type  qwr
);
   import stl_pkg::*;

   localparam logic [3:0] M_IDLE    = 4'd0;
   localparam logic [3:0] M_IDENT   = 4'd1;
   localparam logic [3:0] M_INT     = 4'd2;
   localparam logic [3:0] M_STRING  = 4'd3;
   localparam logic [3:0] M_COMMENT = 4'd4;
   localparam logic [3:0] M_SLASH   = 4'd5;
   localparam logic [3:0] M_EQ      = 4'd6;
   localparam logic [3:0] M_BANG    = 4'd7;
   localparam logic [3:0] M_MINUS   = 4'd8;
   localparam logic [3:0] M_BAR     = 4'd9;
   localparam logic [3:0] M_BARQ    = 4'd10;

   localparam logic [POS_BITS-1:0] POS_ONE = POS_BITS'(1);
   localparam logic [NUM_KW-1:0]   ALL_KW  = '1;

   logic [3:0]          mode_ff,  mode_in;
   logic [POS_BITS-1:0] pos_ff,   pos_in;
   logic [POS_BITS-1:0] start_ff, start_in;
   logic [POS_BITS-1:0] run_ff,   run_in;
   logic [NUM_KW-1:0]   kw_ff,    kw_in;
   bundle_type          b;
   logic                relex;

   function automatic logic [15:0] sat16(input logic [POS_BITS-1:0] v);
      logic [31:0] w;
      w = 32'(v);
      return (w > 32'd65535) ? 16'hFFFF : w[15:0];
   endfunction

   function automatic logic [15:0] lo16(input logic [POS_BITS-1:0] v);
      logic [31:0] w;
      w = 32'(v);
      return w[15:0];
   endfunction

   function automatic logic [POS_BITS-1:0] grow(input logic [POS_BITS-1:0] v);
      return (&v) ? v : v + POS_ONE;
   endfunction

   function automatic logic [NUM_KW-1:0] narrow(input logic [NUM_KW-1:0] kw,
                                                input logic [7:0] c,
                                                input logic [POS_BITS-1:0] idx);
      logic [NUM_KW-1:0] r;
      logic [2:0]        i3;
      logic [63:0]       t;
      r  = kw;
      i3 = idx[2:0];
      for (int k = 0; k < NUM_KW; k++) begin
         t = kw_text(4'(k));
         if (32'(idx) >= 32'd8 || t[8*(7-i3) +: 8] != c)
            r[k] = 1'b0;
      end
      return r;
   endfunction

   function automatic logic [5:0] ident_kind(input logic [NUM_KW-1:0] kw,
                                             input logic [POS_BITS-1:0] run);
      logic [5:0] kd;
      kd = K_IDENT;
      for (int k = 0; k < NUM_KW; k++)
         if (kw[k] && 32'(run) == 32'(kw_len(4'(k))))
            kd = K_KW0 + 6'(k);
      return kd;
   endfunction

   always_comb begin
      mode_in  = mode_ff;
      start_in = start_ff;
      run_in   = run_ff;
      kw_in    = kw_ff;
      b        = '0;
      relex    = 1'b0;

      if (mode_ff == M_IDLE) begin
         relex = 1'b1;
      end else begin
         mode_in = M_IDLE;
         unique case (mode_ff)
            M_IDENT: begin
               if (is_alpha(text_byte) || is_digit(text_byte) || text_byte == "_") begin
                  kw_in   = narrow(kw_ff, text_byte, run_ff);
                  run_in  = grow(run_ff);
                  mode_in = M_IDENT;
               end else begin
                  b     = add_tok(b, ident_kind(kw_ff, run_ff), lo16(start_ff), sat16(run_ff));
                  relex = 1'b1;
               end
            end
            M_INT: begin
               if (is_digit(text_byte)) begin
                  run_in  = grow(run_ff);
                  mode_in = M_INT;
               end else begin
                  b     = add_tok(b, K_INT, lo16(start_ff), sat16(run_ff));
                  relex = 1'b1;
               end
            end
            M_STRING: begin
               run_in = grow(run_ff);
               if (text_byte == "\"")
                  b = add_tok(b, K_STRING, lo16(start_ff), sat16(run_in));
               else
                  mode_in = M_STRING;
            end
            M_COMMENT: begin
               if (text_byte != 8'd10 && text_byte != 8'd13)
                  mode_in = M_COMMENT;
            end
            M_SLASH: begin
               if (text_byte == "/") begin
                  mode_in = M_COMMENT;
               end else begin
                  b     = add_tok(b, K_DIV, lo16(start_ff), 16'd1);
                  relex = 1'b1;
               end
            end
            M_EQ: begin
               if (text_byte == "=") begin
                  b = add_tok(b, K_EQEQ, lo16(start_ff), 16'd2);
               end else begin
                  b     = add_tok(b, K_EQ, lo16(start_ff), 16'd1);
                  relex = 1'b1;
               end
            end
            M_BANG: begin
               if (text_byte == "=") begin
                  b = add_tok(b, K_NE, lo16(start_ff), 16'd2);
               end else begin
                  b     = add_tok(b, K_ERROR, lo16(start_ff), 16'd1);
                  relex = 1'b1;
               end
            end
            M_MINUS: begin
               if (text_byte == ">") begin
                  b = add_tok(b, K_ARROW, lo16(start_ff), 16'd2);
               end else begin
                  b     = add_tok(b, K_MINUS, lo16(start_ff), 16'd1);
                  relex = 1'b1;
               end
            end
            M_BAR: begin
               if (text_byte == "?") begin
                  mode_in = M_BARQ;
               end else if (text_byte == ">") begin
                  b = add_tok(b, K_PIPE, lo16(start_ff), 16'd2);
               end else begin
                  b     = add_tok(b, K_ERROR, lo16(start_ff), 16'd1);
                  relex = 1'b1;
               end
            end
            M_BARQ: begin
               if (text_byte == ">") begin
                  b = add_tok(b, K_RAILPIPE, lo16(start_ff), 16'd3);
               end else begin
                  // bar and question mark each become an error token
                  b     = add_tok(b, K_ERROR, lo16(start_ff), 16'd1);
                  b     = add_tok(b, K_ERROR, lo16(start_ff + POS_ONE), 16'd1);
                  relex = 1'b1;
               end
            end
            default: relex = 1'b1;
         endcase
      end

      if (relex) begin
         start_in = pos_ff;
         run_in   = POS_ONE;
         mode_in  = M_IDLE;
         if (is_space(text_byte)) begin
            mode_in = M_IDLE;
         end else if (is_alpha(text_byte) || text_byte == "_") begin
            mode_in = M_IDENT;
            kw_in   = narrow(ALL_KW, text_byte, '0);
         end else if (is_digit(text_byte)) begin
            mode_in = M_INT;
         end else begin
            unique case (text_byte)
               "\"":    mode_in = M_STRING;
               "/":     mode_in = M_SLASH;
               "=":     mode_in = M_EQ;
               "!":     mode_in = M_BANG;
               "-":     mode_in = M_MINUS;
               "|":     mode_in = M_BAR;
               ".":     b = add_tok(b, K_DOT,    lo16(pos_ff), 16'd1);
               "(":     b = add_tok(b, K_LPAREN, lo16(pos_ff), 16'd1);
               ")":     b = add_tok(b, K_RPAREN, lo16(pos_ff), 16'd1);
               "{":     b = add_tok(b, K_LBRACE, lo16(pos_ff), 16'd1);
               "}":     b = add_tok(b, K_RBRACE, lo16(pos_ff), 16'd1);
               ",":     b = add_tok(b, K_COMMA,  lo16(pos_ff), 16'd1);
               ":":     b = add_tok(b, K_COLON,  lo16(pos_ff), 16'd1);
               ";":     b = add_tok(b, K_SEMI,   lo16(pos_ff), 16'd1);
               "+":     b = add_tok(b, K_PLUS,   lo16(pos_ff), 16'd1);
               "*":     b = add_tok(b, K_MUL,    lo16(pos_ff), 16'd1);
               "<":     b = add_tok(b, K_LT,     lo16(pos_ff), 16'd1);
               ">":     b = add_tok(b, K_GT,     lo16(pos_ff), 16'd1);
               default: b = add_tok(b, K_ERROR,  lo16(pos_ff), 16'd1);
            endcase
         end
      end

      if (last_byte) begin
         unique case (mode_in)
            M_IDENT:  b = add_tok(b, ident_kind(kw_in, run_in), lo16(start_in), sat16(run_in));
            M_INT:    b = add_tok(b, K_INT, lo16(start_in), sat16(run_in));
            M_STRING: b = add_tok(b, K_STRING, lo16(start_in), sat16(run_in));
            M_SLASH:  b = add_tok(b, K_DIV, lo16(start_in), 16'd1);
            M_EQ:     b = add_tok(b, K_EQ, lo16(start_in), 16'd1);
            M_MINUS:  b = add_tok(b, K_MINUS, lo16(start_in), 16'd1);
            M_BANG, M_BAR: b = add_tok(b, K_ERROR, lo16(start_in), 16'd1);
            M_BARQ: begin
               b = add_tok(b, K_ERROR, lo16(start_in), 16'd1);
               b = add_tok(b, K_ERROR, lo16(start_in + POS_ONE), 16'd1);
            end
            default: ;
         endcase
         b       = add_tok(b, K_END, lo16(pos_ff + POS_ONE), 16'd0);
         mode_in = M_IDLE;
         pos_in  = '0;
      end else begin
         pos_in = pos_ff + POS_ONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= M_IDLE;
         pos_ff   <= '0;
         start_ff <= '0;
         run_ff   <= '0;
         kw_ff    <= ALL_KW;
      end else if (take) begin
         mode_ff  <= mode_in;
         pos_ff   <= pos_in;
         start_ff <= start_in;
         run_ff   <= run_in;
         kw_ff    <= kw_in;
      end
   end

   assign qwr.push = take && (b.count != 3'd0);
   assign qwr.data = b;

endmodule

@@ design/stl_queue.sv @@
// Short queue of token bundles between the lexer front end and the token drain.
// Depends on stl_pkg.
`timescale 1ns / 1ps
module stl_queue (
   input  logic                clock,
   input  logic                reset,
   input  stl_pkg::qwr_type    qwr,
   input  logic                rd,
   output logic                full,
   output logic                empty,
   output stl_pkg::bundle_type head
);
   import stl_pkg::*;

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   bundle_type      mem_ff [QUEUE_DEPTH];
   logic [PW-1:0]   wp_ff, wp_in;
   logic [PW-1:0]   rp_ff, rp_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic            do_wr, do_rd;

   assign full  = cnt_ff == CW'(QUEUE_DEPTH);
   assign empty = cnt_ff == '0;
   assign head  = mem_ff[rp_ff];
   assign do_wr = qwr.push && !full;
   assign do_rd = rd && !empty;

   always_comb begin
      wp_in  = do_wr ? wp_ff + PW'(1) : wp_ff;
      rp_in  = do_rd ? rp_ff + PW'(1) : rp_ff;
      cnt_in = cnt_ff + CW'(do_wr) - CW'(do_rd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wp_ff] <= qwr.data;
      end
   end

endmodule

@@ design/stl_back.sv @@
// Token drain: walks the head bundle one token per pop and marks the bundle's last token.
// Depends on stl_pkg.
`timescale 1ns / 1ps
module stl_back (
   input  logic                clock,
   input  logic                reset,
   input  stl_pkg::bundle_type head,
   input  logic                q_empty,
   input  logic                pop,
   output logic                q_rd,
   output logic [5:0]          token_kind,
   output logic [15:0]         token_start,
   output logic [15:0]         token_length,
   output logic                token_last
);
   import stl_pkg::*;

   logic [1:0] idx_ff, idx_in;
   logic       take;
   tok_type    cur;

   assign cur          = head.tok[idx_ff];
   assign token_kind   = cur.kind;
   assign token_start  = cur.start;
   assign token_length = cur.length;
   assign token_last   = 3'(idx_ff) + 3'd1 >= head.count;
   assign take         = pop && !q_empty;
   assign q_rd         = take && token_last;

   always_comb begin
      idx_in = idx_ff;
      if (take)
         idx_in = token_last ? 2'd0 : idx_ff + 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule

@@ design/source_token_lexer.sv @@
// Streaming tokenizer: one source byte per request, tokens out through a queue.
// A token is written to the bundle queue when the byte that ends it is accepted.
// Throughput: one byte per cycle while the queue is not full; tokens drain one per cycle while rsp_pop is
// held, so a burst of bytes that each end several tokens fills the four-entry bundle queue and raises full.
// Reset (synchronous): lexer idle, offset 0, queue empty.
`timescale 1ns / 1ps
module source_token_lexer #(
   parameter int POS_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_text_byte,
   input  logic        req_last_byte,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [5:0]  rsp_token_kind,
   output logic [15:0] rsp_token_start,
   output logic [15:0] rsp_token_length,
   output logic        rsp_token_last
);
   import stl_pkg::*;

   qwr_type    qwr;
   bundle_type head;
   logic       q_full, q_empty, q_rd;

   assign req_full  = q_full;
   assign rsp_empty = q_empty;

   stl_front #(.POS_BITS(POS_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .take      (req_push && !q_full),
      .text_byte (req_text_byte),
      .last_byte (req_last_byte),
      .qwr       (qwr)
   );

   stl_queue u_queue (
      .clock (clock),
      .reset (reset),
      .qwr   (qwr),
      .rd    (q_rd),
      .full  (q_full),
      .empty (q_empty),
      .head  (head)
   );

   stl_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (head),
      .q_empty      (q_empty),
      .pop          (rsp_pop),
      .q_rd         (q_rd),
      .token_kind   (rsp_token_kind),
      .token_start  (rsp_token_start),
      .token_length (rsp_token_length),
      .token_last   (rsp_token_last)
   );

endmodule

@@ design/stl_checker.sv @@
// Port-level checks for the source token lexer, bound to the top level.
// Depends on stl_pkg and source_token_lexer.
`timescale 1ns / 1ps
module stl_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_push,
   input logic        req_full,
   input logic        req_last_byte,
   input logic        rsp_empty,
   input logic        rsp_pop,
   input logic [5:0]  rsp_token_kind,
   input logic [15:0] rsp_token_start,
   input logic [15:0] rsp_token_length,
   input logic        rsp_token_last
);
   import stl_pkg::*;

   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("queue not empty after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_token_kind)
                                 && $stable(rsp_token_start))
      else $error("waiting token changed");

   a_end_follows: assert property (@(posedge clock) disable iff (reset)
      req_push && !req_full && req_last_byte |=> !rsp_empty)
      else $error("no token after final byte");

   a_end_shape: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_token_kind == K_END |-> rsp_token_length == 16'd0 && rsp_token_last)
      else $error("malformed end token");

   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> rsp_token_kind <= K_MAX)
      else $error("token kind out of range");

endmodule

bind source_token_lexer stl_checker u_stl_checker (.*);

@@ test/tb_source_token_lexer.sv @@
// Self-checking testbench for source_token_lexer: byte requests in, tokens out.
// Depends on stl_pkg and source_token_lexer; tokens are predicted here and checked in order.
`timescale 1ns / 1ps
module tb_source_token_lexer;
   import stl_pkg::*;

   typedef enum int {LX_IDLE, LX_IDENT, LX_INT, LX_STRING, LX_COMMENT, LX_SLASH,
                     LX_EQ, LX_BANG, LX_MINUS, LX_BAR, LX_BARQ} lex_mode_type;

   typedef struct {
      bit [5:0]  kind;
      bit [15:0] start;
      bit [15:0] length;
      bit        last;
   } token_type;

   class token_scoreboard;
      token_type    want[$];
      token_type    step_toks[$];
      int           errors;
      lex_mode_type mode;
      bit [15:0]    pos, tok_start, run;
      bit [10:0]    cand;
      string        kwords[11] = '{"fn", "return", "region", "requires", "ensures", "must",
                                   "match", "Ok", "Err", "struct", "or"};

      function new();
         errors = 0;
         mode = LX_IDLE;
         pos = 0;
         tok_start = 0;
         run = 0;
         cand = '1;
      endfunction

      function void emit(bit [5:0] kind, bit [15:0] s, bit [15:0] len);
         token_type t;
         t.kind = kind;
         t.start = s;
         t.length = len;
         t.last = 0;
         if (step_toks.size() < 4) step_toks.push_back(t);
      endfunction

      function bit ident_char(bit [7:0] c);
         return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_" ||
                (c >= "0" && c <= "9");
      endfunction

      function void narrow(bit [7:0] c, int idx);
         for (int k = 0; k < 11; k++)
            if (cand[k] && (idx >= 8 || idx >= kwords[k].len() || kwords[k][idx] != c))
               cand[k] = 0;
      endfunction

      function void emit_ident();
         bit [5:0] kind;
         kind = K_IDENT;
         for (int k = 0; k < 11; k++)
            if (cand[k] && kwords[k].len() == run) kind = K_KW0 + 6'(k);
         emit(kind, tok_start, run);
      endfunction

      function void start_tok(bit [7:0] c, bit [15:0] p);
         tok_start = p;
         run = 1;
         if (c == " " || (c >= 9 && c <= 13)) return;
         if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_") begin
            mode = LX_IDENT;
            cand = '1;
            narrow(c, 0);
            return;
         end
         if (c >= "0" && c <= "9") begin
            mode = LX_INT;
            return;
         end
         case (c)
            "\"": mode = LX_STRING;
            "/": mode = LX_SLASH;
            "=": mode = LX_EQ;
            "!": mode = LX_BANG;
            "-": mode = LX_MINUS;
            "|": mode = LX_BAR;
            ".": emit(K_DOT, p, 1);
            "(": emit(K_LPAREN, p, 1);
            ")": emit(K_RPAREN, p, 1);
            "{": emit(K_LBRACE, p, 1);
            "}": emit(K_RBRACE, p, 1);
            ",": emit(K_COMMA, p, 1);
            ":": emit(K_COLON, p, 1);
            ";": emit(K_SEMI, p, 1);
            "+": emit(K_PLUS, p, 1);
            "*": emit(K_MUL, p, 1);
            "<": emit(K_LT, p, 1);
            ">": emit(K_GT, p, 1);
            default: emit(K_ERROR, p, 1);
         endcase
      endfunction

      // returns 1 when the byte falls outside the pending token and must start a new one
      function bit continue_tok(bit [7:0] c);
         case (mode)
            LX_IDENT: begin
               if (ident_char(c)) begin
                  narrow(c, run);
                  if (run != 16'hFFFF) run++;
                  return 0;
               end
               emit_ident();
            end
            LX_INT: begin
               if (c >= "0" && c <= "9") begin
                  if (run != 16'hFFFF) run++;
                  return 0;
               end
               emit(K_INT, tok_start, run);
            end
            LX_STRING: begin
               if (run != 16'hFFFF) run++;
               if (c == "\"") begin
                  emit(K_STRING, tok_start, run);
                  mode = LX_IDLE;
               end
               return 0;
            end
            LX_COMMENT: begin
               if (c == "\n" || c == "\r") mode = LX_IDLE;
               return 0;
            end
            LX_SLASH: begin
               if (c == "/") begin
                  mode = LX_COMMENT;
                  return 0;
               end
               emit(K_DIV, tok_start, 1);
            end
            LX_EQ: begin
               if (c == "=") begin
                  emit(K_EQEQ, tok_start, 2);
                  mode = LX_IDLE;
                  return 0;
               end
               emit(K_EQ, tok_start, 1);
            end
            LX_BANG: begin
               if (c == "=") begin
                  emit(K_NE, tok_start, 2);
                  mode = LX_IDLE;
                  return 0;
               end
               emit(K_ERROR, tok_start, 1);
            end
            LX_MINUS: begin
               if (c == ">") begin
                  emit(K_ARROW, tok_start, 2);
                  mode = LX_IDLE;
                  return 0;
               end
               emit(K_MINUS, tok_start, 1);
            end
            LX_BAR: begin
               if (c == "?") begin
                  mode = LX_BARQ;
                  return 0;
               end
               if (c == ">") begin
                  emit(K_PIPE, tok_start, 2);
                  mode = LX_IDLE;
                  return 0;
               end
               emit(K_ERROR, tok_start, 1);
            end
            LX_BARQ: begin
               if (c == ">") begin
                  emit(K_RAILPIPE, tok_start, 3);
                  mode = LX_IDLE;
                  return 0;
               end
               emit(K_ERROR, tok_start, 1);
               emit(K_ERROR, tok_start + 16'd1, 1);
            end
            default: ;
         endcase
         mode = LX_IDLE;
         return 1;
      endfunction

      function void flush();
         case (mode)
            LX_IDENT: emit_ident();
            LX_INT: emit(K_INT, tok_start, run);
            LX_STRING: emit(K_STRING, tok_start, run);
            LX_SLASH: emit(K_DIV, tok_start, 1);
            LX_EQ: emit(K_EQ, tok_start, 1);
            LX_MINUS: emit(K_MINUS, tok_start, 1);
            LX_BANG, LX_BAR: emit(K_ERROR, tok_start, 1);
            LX_BARQ: begin
               emit(K_ERROR, tok_start, 1);
               emit(K_ERROR, tok_start + 16'd1, 1);
            end
            default: ;
         endcase
         mode = LX_IDLE;
      endfunction

      function void note_request(bit [7:0] c, bit is_last);
         bit [15:0] p;
         p = pos;
         step_toks.delete();
         if (mode == LX_IDLE) start_tok(c, p);
         else if (continue_tok(c)) start_tok(c, p);
         if (is_last) begin
            flush();
            emit(K_END, p + 16'd1, 0);
            pos = 0;
         end else begin
            pos = p + 16'd1;
         end
         if (step_toks.size() > 0) step_toks[step_toks.size() - 1].last = 1;
         foreach (step_toks[i]) want.push_back(step_toks[i]);
      endfunction

      function void check_token(bit [5:0] kind, bit [15:0] s, bit [15:0] len, bit lst);
         token_type t;
         if (want.size() == 0) begin
            $error("unexpected token kind=%0d start=%0d length=%0d", kind, s, len);
            errors++;
            return;
         end
         t = want.pop_front();
         if (kind != t.kind) begin
            $error("token_kind expected %0d got %0d", t.kind, kind);
            errors++;
         end
         if (s != t.start) begin
            $error("token_start expected %0d got %0d", t.start, s);
            errors++;
         end
         if (len != t.length) begin
            $error("token_length expected %0d got %0d", t.length, len);
            errors++;
         end
         if (lst != t.last) begin
            $error("token_last expected %0d got %0d", t.last, lst);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_push = 0;
   logic        req_full;
   logic [7:0]  req_text_byte = 0;
   logic        req_last_byte = 0;
   logic        rsp_empty;
   logic        rsp_pop = 0;
   logic [5:0]  rsp_token_kind;
   logic [15:0] rsp_token_start;
   logic [15:0] rsp_token_length;
   logic        rsp_token_last;

   token_scoreboard sb = new();
   bit   quiet = 0;
   int   hold_left = 0;
   int   cycles = 0;
   bit [7:0] text[$];

   source_token_lexer dut (.*);

   initial forever #4 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > 2000000) begin
         $display("tb_source_token_lexer: done, errors");
         $finish;
      end
   end

   // token receiver with its own stall pattern
   initial begin
      int gap;
      gap = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_pop && !rsp_empty)
            sb.check_token(rsp_token_kind, rsp_token_start, rsp_token_length, rsp_token_last);
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 0;
         end else if (gap > 0) begin
            gap--;
            rsp_pop <= 0;
         end else begin
            rsp_pop <= 1;
            if (!quiet && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 11);
         end
      end
   end

   task automatic send_byte(bit [7:0] c, bit is_last);
      req_push <= 1;
      req_text_byte <= c;
      req_last_byte <= is_last;
      do @(posedge clock); while (req_full);
      sb.note_request(c, is_last);
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_push <= 0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
   endtask

   // sends the collected text as one buffer, flagging its final byte
   task automatic send_text();
      foreach (text[i]) send_byte(text[i], i == text.size() - 1);
      text.delete();
      req_push <= 0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      while (sb.want.size() > 0) @(posedge clock);
   endtask

   function automatic void add(string s);
      for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
   endfunction

   function automatic void add_fragment();
      string ops[24] = '{".", "(", ")", "{", "}", ",", ":", ";", "+", "*", "/", "==",
                         "=", "!=", "->", "-", "|?>", "|>", "<", ">", "!", "|", "|?", "//"};
      string words[11] = '{"fn", "return", "region", "requires", "ensures", "must",
                           "match", "Ok", "Err", "struct", "or"};
      string s;
      int n;
      case ($urandom_range(0, 9))
         0, 1: add(words[$urandom_range(0, 10)]);
         2: begin
            s = "_aZ09xeqs";
            add(words[$urandom_range(0, 10)]);
            n = $urandom_range(1, 5);
            for (int i = 0; i < n; i++) text.push_back(s[$urandom_range(0, 8)]);
         end
         3: begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++) text.push_back(8'($urandom_range("0", "9")));
         end
         4: begin
            text.push_back("\"");
            n = $urandom_range(0, 5);
            for (int i = 0; i < n; i++) text.push_back(8'($urandom_range(32, 126)) == "\"" ?
                                                        "x" : 8'($urandom_range(32, 126)));
            text.push_back("\"");
         end
         5, 6: add(ops[$urandom_range(0, 23)]);
         7: begin
            add("// ");
            n = $urandom_range(0, 4);
            for (int i = 0; i < n; i++) text.push_back(8'($urandom_range(32, 255)));
            text.push_back($urandom_range(0, 1) ? "\n" : "\r");
         end
         8: text.push_back(8'($urandom_range(0, 255)));
         default: ;
      endcase
      // separator, sometimes none so that tokens run into each other
      case ($urandom_range(0, 5))
         0: ;
         1: text.push_back(8'($urandom_range(9, 13)));
         default: text.push_back(" ");
      endcase
   endfunction

   initial begin
      int sent;
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      add("fn return region requires ensures must match Ok Err struct or returns x_9 _ ");
      add("0123456789 \"s t\" .(){},:;+*/ == = != -> - |?> |> < > ! | |?x a//c\n");
      text.push_back(8'h80);
      text.push_back(8'hFF);
      text.push_back(8'h00);
      add("\"open");
      send_text();
      add("a /");
      send_text();
      add("b|?");
      send_text();
      add("|");
      send_text();
      wait_drained();

      // receiver holds off while requests keep coming, filling the queue
      hold_left = 300;
      repeat (40) add(".");
      send_text();
      wait_drained();

      sent = 0;
      while (sent < 200) begin
         int n;
         n = $urandom_range(2, 10);
         for (int i = 0; i < n; i++) add_fragment();
         if ($urandom_range(0, 5) == 0) add("\"tail");
         if (sent > 140) quiet = 1;
         sent += text.size();
         send_text();
      end

      wait_drained();
      repeat (20) @(posedge clock);
      if (sb.want.size() != 0) begin
         $error("%0d expected tokens never arrived", sb.want.size());
         sb.errors++;
      end
      if (sb.errors == 0) $display("tb_source_token_lexer: done, clean");
      else $display("tb_source_token_lexer: done, errors");
      $finish;
   end
endmodule

@@ filelist.f @@
design/stl_pkg.sv
design/stl_front.sv
design/stl_queue.sv
design/stl_back.sv
design/source_token_lexer.sv
design/stl_checker.sv
test/tb_source_token_lexer.sv
